@@ src/tprm_pkg.sv @@
// Shared types, constants and codes for the three-phase RMS current and rpm monitor.
// No dependencies; every other file refers to it by scoped names.
package tprm_pkg;

  localparam int AdcBitsDef   = 12;
  localparam int CountBitsDef = 16;

  localparam int SUM_W  = 40;
  localparam int NUM_W  = 48;
  localparam int DEN_W  = 40;
  localparam int REM_W  = DEN_W + 1;
  localparam int MA_W   = 15;
  localparam int RPM_W  = 24;
  localparam int CODE_W = 12;
  localparam int FUNC_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int STEP_W = 6;

  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(NUM_W / 2);

  localparam logic [MA_W-1:0]  MA_MAX    = {MA_W{1'b1}};
  localparam logic [RPM_W-1:0] RPM_MAX   = {RPM_W{1'b1}};
  localparam logic [22:0]      RPM_SCALE = 23'd6000000;

  // input functions
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_EDGE    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_CURRENT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RPM     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_TH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOLOAD_TH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd5;

  // report codes
  localparam logic KIND_CURRENT = 1'b0;
  localparam logic KIND_RPM     = 1'b1;
  localparam logic [1:0] CST_OK      = 2'd0;
  localparam logic [1:0] CST_NO_LOAD = 2'd1;
  localparam logic [1:0] CST_FAULT   = 2'd2;
  localparam logic [1:0] ROT_RUNNING = 2'd0;
  localparam logic [1:0] ROT_STOPPED = 2'd1;
  localparam logic [1:0] ROT_FAULT   = 2'd2;

  typedef struct packed {
    logic              start;
    logic              op_sqrt;
    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } du_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] res;
  } du_rsp_t;

endpackage

@@ src/tprm_if.sv @@
// Channel interfaces of the monitor: input items, result items, register writes.
// Field widths come from tprm_pkg.
interface tprm_in_if;
  logic                            valid;
  logic                            ready;
  logic [tprm_pkg::FUNC_W-1:0]     func;
  logic [tprm_pkg::CODE_W-1:0]     offset_code;
  logic [tprm_pkg::CODE_W-1:0]     phase1_code;
  logic [tprm_pkg::CODE_W-1:0]     phase2_code;
  logic [tprm_pkg::CODE_W-1:0]     phase3_code;
  modport source (output valid, func, offset_code, phase1_code, phase2_code, phase3_code,
                  input ready);
  modport sink (input valid, func, offset_code, phase1_code, phase2_code, phase3_code,
                output ready);
endinterface

interface tprm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        report_kind;
  logic [tprm_pkg::MA_W-1:0]   rms_phase1_ma;
  logic [tprm_pkg::MA_W-1:0]   rms_phase2_ma;
  logic [tprm_pkg::MA_W-1:0]   rms_phase3_ma;
  logic [1:0]                  current_status;
  logic [tprm_pkg::RPM_W-1:0]  rpm_hundredths;
  logic [1:0]                  rotation_status;
  modport source (output valid, report_kind, rms_phase1_ma, rms_phase2_ma, rms_phase3_ma,
                  current_status, rpm_hundredths, rotation_status, input ready);
  modport sink (input valid, report_kind, rms_phase1_ma, rms_phase2_ma, rms_phase3_ma,
                current_status, rpm_hundredths, rotation_status, output ready);
endinterface

interface tprm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tprm_pkg::CFG_IDX_W-1:0]    index;
  logic [tprm_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/tprm_divsqrt.sv @@
// Shared bit-serial unit: restoring division (one quotient bit per cycle) and
// digit-by-digit integer square root (one root bit per cycle). Uses tprm_pkg.
module tprm_divsqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tprm_pkg::du_req_t req_i,
  output tprm_pkg::du_rsp_t rsp_o
);

  localparam logic [tprm_pkg::STEP_W-1:0] STEP_ONE = 1;

  logic                            busy_q;
  logic                            done_q;
  logic                            op_sqrt_q;
  logic [tprm_pkg::STEP_W-1:0]     steps_q;
  logic [tprm_pkg::NUM_W-1:0]      num_q;
  logic [tprm_pkg::DEN_W-1:0]      den_q;
  logic [tprm_pkg::REM_W-1:0]      rem_q;
  logic [tprm_pkg::NUM_W-1:0]      res_q;
  logic [tprm_pkg::REM_W-1:0]      a;
  logic [tprm_pkg::REM_W-1:0]      b;
  logic [tprm_pkg::REM_W:0]        diff;
  logic                            ge;

  // one shared subtractor: partial remainder against divisor or trial root
  always_comb begin
    if (op_sqrt_q) begin
      a = {rem_q[tprm_pkg::REM_W-3:0], num_q[tprm_pkg::NUM_W-1 -: 2]};
      b = {res_q[tprm_pkg::REM_W-3:0], 2'b01};
    end else begin
      a = {rem_q[tprm_pkg::DEN_W-1:0], num_q[tprm_pkg::NUM_W-1]};
      b = {1'b0, den_q};
    end
    diff = {1'b0, a} - {1'b0, b};
    ge   = ~diff[tprm_pkg::REM_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        steps_q <= req_i.op_sqrt ? tprm_pkg::SQRT_STEPS : tprm_pkg::DIV_STEPS;
      end else if (busy_q) begin
        steps_q <= steps_q - 1'b1;
        if (steps_q == STEP_ONE) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_sqrt_q <= req_i.op_sqrt;
      num_q     <= req_i.num;
      den_q     <= req_i.den;
      rem_q     <= '0;
      res_q     <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[tprm_pkg::REM_W-1:0] : a;
      res_q <= {res_q[tprm_pkg::NUM_W-2:0], ge};
      num_q <= op_sqrt_q ? {num_q[tprm_pkg::NUM_W-3:0], 2'b00}
                         : {num_q[tprm_pkg::NUM_W-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

@@ src/three_phase_rms_and_rpm_monitor_top.sv @@
// Top level: sequencer, accumulators, counters and result register of the monitor.
// Sequence: a sample squares and accumulates each phase in turn; a current report runs
//   division, root, multiply and scale per phase for three phases, then the push, or
//   just the push with an empty window; an rpm report divides unless the divisor is zero
//   and adds the phase-one RMS when the window holds samples. A held result adds stalls.
// Throughput: one item at a time; ready only while the sequencer is idle.
// Reset: asynchronous active low; clears sums, counters, timers and registers to defaults.
module three_phase_rms_and_rpm_monitor_top #(
  parameter int ADC_BITS   = tprm_pkg::AdcBitsDef,
  parameter int COUNT_BITS = tprm_pkg::CountBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tprm_in_if.sink    in_i,
  tprm_out_if.source out_o,
  tprm_cfg_if.sink   cfg_i
);

  localparam int SQ_W = 2 * ADC_BITS;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQ    = 4'd1;
  localparam logic [3:0] ST_ACC   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_DIVW  = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_SQRTW = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;
  localparam logic [3:0] ST_RDEN  = 4'd9;
  localparam logic [3:0] ST_RNUM  = 4'd10;
  localparam logic [3:0] ST_RDIV  = 4'd11;
  localparam logic [3:0] ST_RDIVW = 4'd12;
  localparam logic [3:0] ST_ROT   = 4'd13;
  localparam logic [3:0] ST_PUSH  = 4'd14;

  // configuration
  logic [6:0]  holes_q;
  logic [15:0] timeout_q;
  logic [14:0] fault_th_q;
  logic [14:0] noload_th_q;
  logic [15:0] min_samp_q;
  logic [23:0] gain_q;

  // architectural state
  logic [3:0]                  state_q, state_d;
  logic [tprm_pkg::SUM_W-1:0]  sum_q [3];
  logic [tprm_pkg::SUM_W-1:0]  sum_d [3];
  logic [COUNT_BITS-1:0]       cnt_q, cnt_d;
  logic [15:0]                 edge_q, edge_d;
  logic [31:0]                 ms_q, ms_d;
  logic [31:0]                 last_edge_q, last_edge_d;
  logic [31:0]                 last_rep_q, last_rep_d;

  // work registers
  logic [ADC_BITS-1:0]         code_q [3];
  logic [ADC_BITS-1:0]         code_d [3];
  logic [ADC_BITS-1:0]         off_q, off_d;
  logic [1:0]                  ph_q, ph_d;
  logic                        rpm_mode_q, rpm_mode_d;
  logic [SQ_W-1:0]             sq_q, sq_d;
  logic [tprm_pkg::NUM_W-1:0]  res_q, res_d;
  logic [tprm_pkg::NUM_W-1:0]  prod_q, prod_d;
  logic [tprm_pkg::MA_W-1:0]   ma_q [3];
  logic [tprm_pkg::MA_W-1:0]   ma_d [3];
  logic [tprm_pkg::RPM_W-1:0]  rpm_q, rpm_d;
  logic [38:0]                 den_q, den_d;
  logic [39:0]                 num_q, num_d;

  // result register
  logic                        ov_q, ov_d;
  logic                        o_kind_q, o_kind_d;
  logic [tprm_pkg::MA_W-1:0]   o_ma_q [3];
  logic [tprm_pkg::MA_W-1:0]   o_ma_d [3];
  logic [1:0]                  o_cst_q, o_cst_d;
  logic [tprm_pkg::RPM_W-1:0]  o_rpm_q, o_rpm_d;
  logic [1:0]                  o_rot_q, o_rot_d;

  tprm_pkg::du_req_t du_req;
  tprm_pkg::du_rsp_t du_rsp;

  logic                        in_acc;
  logic                        out_acc;
  logic [ADC_BITS-1:0]         code_in [3];
  logic [ADC_BITS-1:0]         off_in;

  tprm_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (du_req),
    .rsp_o  (du_rsp)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid & in_i.ready;
  assign out_acc     = ov_q & out_o.ready;
  assign cfg_i.ready = 1'b1;

  // take each code in its low ADC_BITS bits
  assign off_in     = ADC_BITS'({4'b0000, in_i.offset_code});
  assign code_in[0] = ADC_BITS'({4'b0000, in_i.phase1_code});
  assign code_in[1] = ADC_BITS'({4'b0000, in_i.phase2_code});
  assign code_in[2] = ADC_BITS'({4'b0000, in_i.phase3_code});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holes_q     <= 7'd6;
      timeout_q   <= 16'd2000;
      fault_th_q  <= 15'd500;
      noload_th_q <= 15'd50;
      min_samp_q  <= 16'd10;
      gain_q      <= 24'd352086;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        tprm_pkg::CFG_HOLES:     holes_q     <= cfg_i.data[6:0];
        tprm_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_i.data[15:0];
        tprm_pkg::CFG_FAULT_TH:  fault_th_q  <= cfg_i.data[14:0];
        tprm_pkg::CFG_NOLOAD_TH: noload_th_q <= cfg_i.data[14:0];
        tprm_pkg::CFG_MIN_SAMP:  min_samp_q  <= cfg_i.data[15:0];
        tprm_pkg::CFG_GAIN:      gain_q      <= cfg_i.data[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [ADC_BITS-1:0]        c_sel;
    logic [ADC_BITS-1:0]        d_abs;
    logic [tprm_pkg::SUM_W-1:0] s_sel;
    logic [tprm_pkg::SUM_W:0]   s_add;
    logic [tprm_pkg::NUM_W:0]   rnd;
    logic [28:0]                ma_raw;
    logic [tprm_pkg::MA_W-1:0]  ma_new;
    logic [31:0]                since_edge;
    logic [23:0]                cnt_w;
    logic [23:0]                min_w;
    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    edge_d      = edge_q;
    ms_d        = ms_q;
    last_edge_d = last_edge_q;
    last_rep_d  = last_rep_q;
    code_d      = code_q;
    off_d       = off_q;
    ph_d        = ph_q;
    rpm_mode_d  = rpm_mode_q;
    sq_d        = sq_q;
    res_d       = res_q;
    prod_d      = prod_q;
    ma_d        = ma_q;
    rpm_d       = rpm_q;
    den_d       = den_q;
    num_d       = num_q;
    ov_d        = out_acc ? 1'b0 : ov_q;
    o_kind_d    = o_kind_q;
    o_ma_d      = o_ma_q;
    o_cst_d     = o_cst_q;
    o_rpm_d     = o_rpm_q;
    o_rot_d     = o_rot_q;
    du_req      = '0;

    c_sel = code_q[0];
    s_sel = sum_q[0];
    for (int k = 1; k < 3; k++) begin
      if (ph_q == 2'(k)) begin
        c_sel = code_q[k];
        s_sel = sum_q[k];
      end
    end
    d_abs      = (c_sel >= off_q) ? (c_sel - off_q) : (off_q - c_sel);
    s_add      = {1'b0, s_sel} + (tprm_pkg::SUM_W + 1)'(sq_q);
    rnd        = {1'b0, prod_q} + (tprm_pkg::NUM_W + 1)'(1 << 19);
    ma_raw     = rnd[48:20];
    ma_new     = (ma_raw > 29'(tprm_pkg::MA_MAX)) ? tprm_pkg::MA_MAX : ma_raw[14:0];
    since_edge = ms_q - last_edge_q;
    cnt_w      = 24'(cnt_q);
    min_w      = 24'(min_samp_q);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.func)
            tprm_pkg::FUNC_SAMPLE: begin
              if (!(&cnt_q)) begin
                code_d  = code_in;
                off_d   = off_in;
                ph_d    = 2'd0;
                state_d = ST_SQ;
              end
            end
            tprm_pkg::FUNC_EDGE: begin
              if (!(&edge_q)) edge_d = edge_q + 1'b1;
              last_edge_d = ms_q;
            end
            tprm_pkg::FUNC_TICK: ms_d = ms_q + 1'b1;
            tprm_pkg::FUNC_CURRENT: begin
              rpm_mode_d = 1'b0;
              ph_d       = 2'd0;
              for (int k = 0; k < 3; k++) ma_d[k] = '0;
              state_d = (cnt_q == '0) ? ST_PUSH : ST_DIV;
            end
            tprm_pkg::FUNC_RPM: begin
              rpm_mode_d = 1'b1;
              ph_d       = 2'd0;
              ma_d[0]    = '0;
              state_d    = ST_RDEN;
            end
            default: ;
          endcase
        end
      end
      ST_SQ: begin
        sq_d    = SQ_W'(d_abs) * SQ_W'(d_abs);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        for (int k = 0; k < 3; k++) begin
          if (ph_q == 2'(k)) begin
            sum_d[k] = s_add[tprm_pkg::SUM_W] ? {tprm_pkg::SUM_W{1'b1}}
                                              : s_add[tprm_pkg::SUM_W-1:0];
          end
        end
        if (ph_q == 2'd2) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_IDLE;
        end else begin
          ph_d    = ph_q + 1'b1;
          state_d = ST_SQ;
        end
      end
      ST_DIV: begin
        du_req.start   = 1'b1;
        du_req.op_sqrt = 1'b0;
        du_req.num     = {s_sel, 8'h00};
        du_req.den     = tprm_pkg::DEN_W'(cnt_q);
        state_d        = ST_DIVW;
      end
      ST_DIVW: begin
        if (du_rsp.done) begin
          res_d   = du_rsp.res;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        du_req.start   = 1'b1;
        du_req.op_sqrt = 1'b1;
        du_req.num     = res_q;
        state_d        = ST_SQRTW;
      end
      ST_SQRTW: begin
        if (du_rsp.done) begin
          res_d   = du_rsp.res;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = tprm_pkg::NUM_W'(res_q[23:0]) * tprm_pkg::NUM_W'(gain_q);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          if (ph_q == 2'(k)) ma_d[k] = ma_new;
        end
        if (rpm_mode_q || ph_q == 2'd2) begin
          state_d = ST_PUSH;
        end else begin
          ph_d    = ph_q + 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_RDEN: begin
        den_d   = 39'(holes_q) * 39'(ms_q - last_rep_q);
        state_d = ST_RNUM;
      end
      ST_RNUM: begin
        num_d = 40'(40'(edge_q) * 40'(tprm_pkg::RPM_SCALE)) + 40'(den_q >> 1);
        if (den_q == '0) begin
          rpm_d   = tprm_pkg::RPM_MAX;
          state_d = ST_ROT;
        end else begin
          state_d = ST_RDIV;
        end
      end
      ST_RDIV: begin
        du_req.start   = 1'b1;
        du_req.op_sqrt = 1'b0;
        du_req.num     = tprm_pkg::NUM_W'(num_q);
        du_req.den     = tprm_pkg::DEN_W'(den_q);
        state_d        = ST_RDIVW;
      end
      ST_RDIVW: begin
        if (du_rsp.done) begin
          rpm_d   = (du_rsp.res > tprm_pkg::NUM_W'(tprm_pkg::RPM_MAX))
                    ? tprm_pkg::RPM_MAX : du_rsp.res[tprm_pkg::RPM_W-1:0];
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        // phase-one RMS is needed for the tachometer fault check
        state_d = (cnt_q != '0) ? ST_DIV : ST_PUSH;
      end
      ST_PUSH: begin
        if (!ov_q || out_o.ready) begin
          ov_d     = 1'b1;
          o_kind_d = rpm_mode_q;
          if (!rpm_mode_q) begin
            o_ma_d  = ma_q;
            o_rpm_d = '0;
            o_rot_d = tprm_pkg::ROT_RUNNING;
            if (cnt_q == '0 || cnt_w < min_w) begin
              o_cst_d = tprm_pkg::CST_FAULT;
            end else if (ma_q[0] < noload_th_q && ma_q[1] < noload_th_q &&
                         ma_q[2] < noload_th_q) begin
              o_cst_d = tprm_pkg::CST_NO_LOAD;
            end else begin
              o_cst_d = tprm_pkg::CST_OK;
            end
            for (int k = 0; k < 3; k++) sum_d[k] = '0;
            cnt_d = '0;
          end else begin
            for (int k = 0; k < 3; k++) o_ma_d[k] = '0;
            o_cst_d = tprm_pkg::CST_OK;
            o_rpm_d = rpm_q;
            if (since_edge < 32'(timeout_q)) begin
              o_rot_d = tprm_pkg::ROT_RUNNING;
            end else if (cnt_q != '0 && ma_q[0] < fault_th_q) begin
              o_rot_d = tprm_pkg::ROT_FAULT;
            end else begin
              o_rot_d = tprm_pkg::ROT_STOPPED;
            end
            last_rep_d = ms_q;
            edge_d     = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
      cnt_q       <= '0;
      edge_q      <= '0;
      ms_q        <= '0;
      last_edge_q <= '0;
      last_rep_q  <= '0;
      rpm_mode_q  <= 1'b0;
      ph_q        <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      edge_q      <= edge_d;
      ms_q        <= ms_d;
      last_edge_q <= last_edge_d;
      last_rep_q  <= last_rep_d;
      rpm_mode_q  <= rpm_mode_d;
      ph_q        <= ph_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    off_q    <= off_d;
    sq_q     <= sq_d;
    res_q    <= res_d;
    prod_q   <= prod_d;
    ma_q     <= ma_d;
    rpm_q    <= rpm_d;
    den_q    <= den_d;
    num_q    <= num_d;
    o_kind_q <= o_kind_d;
    o_ma_q   <= o_ma_d;
    o_cst_q  <= o_cst_d;
    o_rpm_q  <= o_rpm_d;
    o_rot_q  <= o_rot_d;
  end

  assign out_o.valid           = ov_q;
  assign out_o.report_kind     = o_kind_q;
  assign out_o.rms_phase1_ma   = o_ma_q[0];
  assign out_o.rms_phase2_ma   = o_ma_q[1];
  assign out_o.rms_phase3_ma   = o_ma_q[2];
  assign out_o.current_status  = o_cst_q;
  assign out_o.rpm_hundredths  = o_rpm_q;
  assign out_o.rotation_status = o_rot_q;

  // a completed sample bumps the count by exactly one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && ph_q == 2'd2) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("sample count did not advance by one");

  // the shared unit only answers while the sequencer waits for it
  a_du_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    du_rsp.done |-> (state_q == ST_DIVW || state_q == ST_SQRTW || state_q == ST_RDIVW))
    else $error("shared unit finished outside a wait state");

  // a fresh current report leaves an empty window behind
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(ov_q) && o_kind_q == tprm_pkg::KIND_CURRENT) |-> (cnt_q == '0))
    else $error("window not cleared after current report");

endmodule

@@ verif/three_phase_rms_and_rpm_monitor_top_test.sv @@
// Self-checking test of the three-phase RMS current and rpm monitor top level.
// Depends on tprm_pkg and the channel interfaces in tprm_if.sv; an in-bench monitor
// model predicts every report, and a small scoreboard class compares them.
`timescale 1ns / 1ps

module three_phase_rms_and_rpm_monitor_top_test;

  localparam int unsigned LIMIT_CYCLES = 6000000;
  localparam int unsigned END_DRAIN    = 400;

  typedef struct packed {
    logic                       kind;
    logic [tprm_pkg::MA_W-1:0]  ph1;
    logic [tprm_pkg::MA_W-1:0]  ph2;
    logic [tprm_pkg::MA_W-1:0]  ph3;
    logic [1:0]                 cst;
    logic [tprm_pkg::RPM_W-1:0] rpm;
    logic [1:0]                 rot;
  } report_t;

  class monitor_scoreboard;
    bit [6:0]  holes;
    bit [15:0] timeout_ms;
    bit [14:0] fault_th;
    bit [14:0] noload_th;
    bit [15:0] min_samp;
    bit [23:0] gain;
    bit [39:0] sum_a, sum_b, sum_c;
    bit [15:0] n_samples, n_edges;
    bit [31:0] ms_now, ms_edge, ms_report;
    report_t   pending_reports[$];
    int unsigned mismatches, reports_seen, current_seen, rpm_seen;

    function void reset_state();
      holes = 6; timeout_ms = 2000; fault_th = 500; noload_th = 50;
      min_samp = 10; gain = 352086;
      sum_a = 0; sum_b = 0; sum_c = 0; n_samples = 0; n_edges = 0;
      ms_now = 0; ms_edge = 0; ms_report = 0;
    endfunction

    function void write_reg(logic [tprm_pkg::CFG_IDX_W-1:0] idx,
                            logic [tprm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tprm_pkg::CFG_HOLES:     holes = data[6:0];
        tprm_pkg::CFG_TIMEOUT:   timeout_ms = data[15:0];
        tprm_pkg::CFG_FAULT_TH:  fault_th = data[14:0];
        tprm_pkg::CFG_NOLOAD_TH: noload_th = data[14:0];
        tprm_pkg::CFG_MIN_SAMP:  min_samp = data[15:0];
        tprm_pkg::CFG_GAIN:      gain = data;
        default: ;
      endcase
    endfunction

    function bit [63:0] int_root(bit [63:0] v);
      bit [63:0] root, probe;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        probe = root | (64'd1 << b);
        if (probe * probe <= v) root = probe;
      end
      return root;
    endfunction

    function bit [14:0] phase_ma(bit [39:0] sum);
      bit [63:0] q4, ma;
      q4 = int_root((64'(sum) << 8) / n_samples);
      ma = (q4 * gain + (64'd1 << 19)) >> 20;
      return (ma > 64'(tprm_pkg::MA_MAX)) ? tprm_pkg::MA_MAX : ma[14:0];
    endfunction

    function bit [39:0] add_sq(bit [39:0] sum, bit [11:0] code, bit [11:0] off);
      bit [63:0] d, s;
      d = (code >= off) ? 64'(code - off) : 64'(off - code);
      s = 64'(sum) + d * d;
      return (s > 64'h00FF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
    endfunction

    function void note_input(logic [tprm_pkg::FUNC_W-1:0] f, logic [11:0] off,
                             logic [11:0] p1, logic [11:0] p2, logic [11:0] p3);
      report_t r;
      bit [63:0] elapsed, den, rpm;
      r = '0;
      case (f)
        tprm_pkg::FUNC_SAMPLE: begin
          if (n_samples != 16'hFFFF) begin
            sum_a = add_sq(sum_a, p1, off);
            sum_b = add_sq(sum_b, p2, off);
            sum_c = add_sq(sum_c, p3, off);
            n_samples++;
          end
        end
        tprm_pkg::FUNC_EDGE: begin
          if (n_edges != 16'hFFFF) n_edges++;
          ms_edge = ms_now;
        end
        tprm_pkg::FUNC_TICK: ms_now++;
        tprm_pkg::FUNC_CURRENT: begin
          r.kind = tprm_pkg::KIND_CURRENT;
          r.cst = tprm_pkg::CST_FAULT;
          if (n_samples != 0) begin
            r.ph1 = phase_ma(sum_a);
            r.ph2 = phase_ma(sum_b);
            r.ph3 = phase_ma(sum_c);
            if (n_samples < min_samp) r.cst = tprm_pkg::CST_FAULT;
            else if (r.ph1 < noload_th && r.ph2 < noload_th && r.ph3 < noload_th)
              r.cst = tprm_pkg::CST_NO_LOAD;
            else r.cst = tprm_pkg::CST_OK;
          end
          sum_a = 0; sum_b = 0; sum_c = 0; n_samples = 0;
          pending_reports.push_back(r);
        end
        tprm_pkg::FUNC_RPM: begin
          r.kind = tprm_pkg::KIND_RPM;
          elapsed = 64'(ms_now - ms_report);
          den = 64'(holes) * elapsed;
          if (den == 0) rpm = 64'(tprm_pkg::RPM_MAX);
          else begin
            rpm = (64'(n_edges) * 64'd6000000 + den / 2) / den;
            if (rpm > 64'(tprm_pkg::RPM_MAX)) rpm = 64'(tprm_pkg::RPM_MAX);
          end
          r.rpm = rpm[23:0];
          if (32'(ms_now - ms_edge) < 32'(timeout_ms)) r.rot = tprm_pkg::ROT_RUNNING;
          else if (n_samples != 0 && phase_ma(sum_a) < fault_th)
            r.rot = tprm_pkg::ROT_FAULT;
          else r.rot = tprm_pkg::ROT_STOPPED;
          ms_report = ms_now;
          n_edges = 0;
          pending_reports.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_report(report_t got);
      report_t exp_r;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected report %p", got);
        return;
      end
      exp_r = pending_reports.pop_front();
      reports_seen++;
      if (exp_r.kind == tprm_pkg::KIND_RPM) rpm_seen++; else current_seen++;
      if (got.kind !== exp_r.kind || got.ph1 !== exp_r.ph1 || got.ph2 !== exp_r.ph2 ||
          got.ph3 !== exp_r.ph3 || got.cst !== exp_r.cst || got.rpm !== exp_r.rpm ||
          got.rot !== exp_r.rot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: report %0d expected %p got %p", reports_seen, exp_r, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  tprm_in_if  in_ch();
  tprm_out_if out_ch();
  tprm_cfg_if cfg_ch();

  three_phase_rms_and_rpm_monitor_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  monitor_scoreboard sb = new();
  bit no_idle = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = tprm_pkg::FUNC_TICK;
    in_ch.offset_code = '0;
    in_ch.phase1_code = '0;
    in_ch.phase2_code = '0;
    in_ch.phase3_code = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = tprm_pkg::CFG_HOLES;
    cfg_ch.data = '0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // note each accepted input transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.func, in_ch.offset_code, in_ch.phase1_code,
                    in_ch.phase2_code, in_ch.phase3_code);
  end

  // result side: stall a random number of cycles per transaction, then accept
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      repeat (stall) @(negedge clk_i);
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      sb.check_report({out_ch.report_kind, out_ch.rms_phase1_ma, out_ch.rms_phase2_ma,
                       out_ch.rms_phase3_ma, out_ch.current_status,
                       out_ch.rpm_hundredths, out_ch.rotation_status});
      @(negedge clk_i);
      out_ch.ready = 1'b0;
    end
  end

  task automatic send_item(logic [tprm_pkg::FUNC_W-1:0] f, logic [11:0] off = 12'd2048,
                           logic [11:0] p1 = '0, logic [11:0] p2 = '0,
                           logic [11:0] p3 = '0);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.func = f;
    in_ch.offset_code = off;
    in_ch.phase1_code = p1;
    in_ch.phase2_code = p2;
    in_ch.phase3_code = p3;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    if (f <= tprm_pkg::FUNC_RPM) items_sent++;
  endtask

  task automatic end_burst();
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    end_burst();
    while (sb.pending_reports.size() != 0) @(negedge clk_i);
    // a trailing sample may still be in flight
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [tprm_pkg::CFG_IDX_W-1:0] idx,
                           logic [tprm_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_regs(int holes, int tmo, int fth, int nth, int mins, int gain);
    drain();
    write_reg(tprm_pkg::CFG_HOLES, 24'(holes));
    write_reg(tprm_pkg::CFG_TIMEOUT, 24'(tmo));
    write_reg(tprm_pkg::CFG_FAULT_TH, 24'(fth));
    write_reg(tprm_pkg::CFG_NOLOAD_TH, 24'(nth));
    write_reg(tprm_pkg::CFG_MIN_SAMP, 24'(mins));
    write_reg(tprm_pkg::CFG_GAIN, 24'(gain));
  endtask

  task automatic random_sample();
    logic [11:0] off;
    off = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(1900, 2200));
    send_item(tprm_pkg::FUNC_SAMPLE, off, 12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  // one measurement window: samples, edges, ticks, some current reports and unused codes, then reports
  task automatic random_window();
    int unsigned n;
    n = $urandom_range(0, 30);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: random_sample();
        5, 6: send_item(tprm_pkg::FUNC_EDGE);
        7, 8: send_item(tprm_pkg::FUNC_TICK);
        default: begin
          if ($urandom_range(0, 3) == 0) send_item(tprm_pkg::FUNC_CURRENT);
          else send_item(3'($urandom_range(5, 7)), 12'($urandom), 12'($urandom),
                         12'($urandom), 12'($urandom));
        end
      endcase
    end
    if ($urandom_range(0, 3) != 0) send_item(tprm_pkg::FUNC_RPM);
    if ($urandom_range(0, 4) != 0) send_item(tprm_pkg::FUNC_CURRENT);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    sb.reset_state();
    @(negedge clk_i);

    // directed: empty window, zero elapsed, code extremes, few samples
    send_item(tprm_pkg::FUNC_CURRENT);
    send_item(tprm_pkg::FUNC_RPM);
    send_item(tprm_pkg::FUNC_SAMPLE, 12'd0, 12'd4095, 12'd0, 12'd4095);
    send_item(tprm_pkg::FUNC_SAMPLE, 12'd4095, 12'd0, 12'd4095, 12'd2048);
    send_item(tprm_pkg::FUNC_SAMPLE, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
    send_item(tprm_pkg::FUNC_CURRENT);
    for (int i = 0; i < 12; i++)
      send_item(tprm_pkg::FUNC_SAMPLE, 12'd2048, 12'd2049, 12'd2048, 12'd2047);
    send_item(tprm_pkg::FUNC_EDGE);
    send_item(tprm_pkg::FUNC_TICK);
    send_item(tprm_pkg::FUNC_TICK);
    send_item(tprm_pkg::FUNC_RPM);
    send_item(tprm_pkg::FUNC_CURRENT);
    send_item(3'd7, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);

    // full-scale samples, milliamp saturation and rpm saturation on one tick
    set_regs(1, 1, 32767, 32767, 65535, 16777215);
    no_idle = 1'b1;
    for (int i = 0; i < 20; i++)
      send_item(tprm_pkg::FUNC_SAMPLE, 12'd0, 12'd4095, 12'd4095, 12'd4095);
    for (int i = 0; i < 5; i++) send_item(tprm_pkg::FUNC_EDGE);
    send_item(tprm_pkg::FUNC_TICK);
    send_item(tprm_pkg::FUNC_RPM);
    send_item(tprm_pkg::FUNC_CURRENT);
    no_idle = 1'b0;

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_regs(6, 2000, 500, 50, 10, 352086);
        1: set_regs(1, 1, 32767, 32767, 65535, 16777215);
        2: set_regs(64, 65535, 0, 0, 1, 0);
        3: set_regs($urandom_range(1, 64), $urandom_range(1, 20), $urandom_range(0, 32767),
                    $urandom_range(0, 32767), $urandom_range(1, 20),
                    $urandom_range(0, 16777215));
        default: set_regs($urandom_range(1, 64), $urandom_range(1, 65535),
                          $urandom_range(0, 2000), $urandom_range(0, 500),
                          $urandom_range(1, 40), $urandom_range(100000, 900000));
      endcase
      for (int w = 0; items_sent < 200 * (phase + 1); w++) begin
        if (phase == 0 && w == 10) drain();
        no_idle = ($urandom_range(0, 7) == 0);
        random_window();
      end
      no_idle = 1'b0;
    end

    drain();
    repeat (END_DRAIN) @(negedge clk_i);
    $display("Covered %0d input items: %0d current and %0d rpm reports under several",
             items_sent, sb.current_seen, sb.rpm_seen);
    $display("register settings, with empty windows, saturated outputs and zero elapsed time.");
    if (sb.mismatches == 0 && sb.pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d, missing reports: %0d", sb.mismatches,
               sb.pending_reports.size());
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/tprm_pkg.sv
src/tprm_if.sv
src/tprm_divsqrt.sv
src/three_phase_rms_and_rpm_monitor_top.sv
verif/three_phase_rms_and_rpm_monitor_top_test.sv
